FILE: rtl/pss_pkg.sv
package pss_pkg;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_BAD_REG   = 2'd2;

  localparam logic [2:0] REG_VF_COUNT  = 3'd0;
  localparam logic [2:0] REG_VENDOR    = 3'd1;
  localparam logic [2:0] REG_PF_DEV    = 3'd2;
  localparam logic [2:0] REG_VF_DEV    = 3'd3;
  localparam logic [2:0] REG_SUBSYS    = 3'd4;
  localparam logic [2:0] REG_BAR_FLAGS = 3'd5;
  localparam logic [2:0] REG_PF_CLASS  = 3'd6;
  localparam logic [2:0] REG_VF_CLASS  = 3'd7;

  localparam logic [11:0] OFF_BAR_BASE = 12'h010;
  localparam logic [11:0] OFF_BAR_END  = 12'h028;
  localparam logic [11:0] OFF_ROM      = 12'h030;

  localparam int OVL_N = 18;

  typedef enum logic [4:0] {
    OVL_NONE  = 5'd0,
    OVL_VEN0  = 5'd1,
    OVL_VEN1  = 5'd2,
    OVL_DEV0  = 5'd3,
    OVL_DEV1  = 5'd4,
    OVL_CLS0  = 5'd5,
    OVL_CLS1  = 5'd6,
    OVL_CLS2  = 5'd7,
    OVL_SUB0  = 5'd8,
    OVL_SUB1  = 5'd9,
    OVL_SUB2  = 5'd10,
    OVL_SUB3  = 5'd11,
    OVL_BARF  = 5'd12,
    OVL_SDEV0 = 5'd13,
    OVL_SDEV1 = 5'd14,
    OVL_SBARF = 5'd15,
    OVL_NUM0  = 5'd16,
    OVL_NUM1  = 5'd17
  } ovl_t;

  localparam logic [OVL_N-1:0] NUM_MASK = 18'h30000;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DATA
  } st_t;

  typedef struct packed {
    logic       en;
    logic [1:0] sel;
    logic [9:0] row;
    ovl_t       ovl;
  } lane_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [1:0]  status;
    logic        is_wr;
    logic [31:0] wdata;
    lane_t [3:0] lanes;
  } op_t;

  typedef struct packed {
    logic [2:0]  vf_count;
    logic [15:0] vendor_id;
    logic [15:0] pf_device_id;
    logic [15:0] vf_device_id;
    logic [31:0] subsystem_ids;
    logic [3:0]  bar_flag_bits;
    logic [23:0] pf_class_code;
    logic [23:0] vf_class_code;
  } cfg_t;

  typedef struct packed {
    logic       ident;
    logic       num;
    logic [7:0] init;
  } cfg_evt_t;

endpackage

FILE: rtl/pss_ram.sv
module pss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: rtl/pss_fifo.sv
module pss_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pss_pkg::op_t  op_in,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output pss_pkg::op_t  op_out
);
  import pss_pkg::*;

  op_t        mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full   = cnt == 2'd2;
  assign valid  = cnt != 2'd0;
  assign op_out = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= op_in;
    end
  end

endmodule

FILE: rtl/pss_front.sv
module pss_front #(
  parameter int MAX_VIRTUAL_FUNCS = 7,
  parameter int SPACE_BYTES       = 4096,
  parameter int SRIOV_CAP_AT      = 256,
  parameter int BAR0_BYTES        = 4096
) (
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,
  input  pss_pkg::cfg_t cfg,
  input  logic         clearing,
  input  logic         fifo_full,
  output logic         push,
  output pss_pkg::op_t op
);
  import pss_pkg::*;

  localparam int          NFUNC = MAX_VIRTUAL_FUNCS + 1;
  localparam logic [11:0] S     = 12'(SRIOV_CAP_AT);
  localparam logic [11:0] SBAR  = S + 12'h024;
  localparam logic [11:0] SEND  = S + 12'h03C;
  localparam logic [31:0] MASK  = 32'(BAR0_BYTES - 1);

  function automatic ovl_t ovl_of(logic [11:0] a, logic pf);
    ovl_t o;
    o = OVL_NONE;
    unique case (a)
      12'h000: o = OVL_VEN0;
      12'h001: o = OVL_VEN1;
      12'h002: o = OVL_DEV0;
      12'h003: o = OVL_DEV1;
      12'h009: o = OVL_CLS0;
      12'h00A: o = OVL_CLS1;
      12'h00B: o = OVL_CLS2;
      12'h02C: o = OVL_SUB0;
      12'h02D: o = OVL_SUB1;
      12'h02E: o = OVL_SUB2;
      12'h02F: o = OVL_SUB3;
      12'h010: o = OVL_BARF;
      default: o = OVL_NONE;
    endcase
    if (pf) begin
      if (a == S + 12'h010) o = OVL_NUM0;
      if (a == S + 12'h011) o = OVL_NUM1;
      if (a == S + 12'h01A) o = OVL_SDEV0;
      if (a == S + 12'h01B) o = OVL_SDEV1;
      if (a == SBAR)        o = OVL_SBARF;
    end
    return o;
  endfunction

  logic        is_wr;
  logic [7:0]  bus;
  logic [4:0]  slot;
  logic [2:0]  func;
  logic [11:0] where;
  logic [2:0]  size;
  logic [31:0] wdata;
  logic        is_pf;
  logic        not_found;
  logic        bad;
  logic        bar_hit;
  logic        rom_hit;
  logic        sbar_hit;
  logic        sreg_hit;
  logic        ident;
  logic        drop;
  logic [11:0] bar_off;
  logic [2:0]  bar_num;
  logic [31:0] bar_data;
  logic [1:0]  sel;
  logic [11:0] a;

  assign is_wr = s_tdata[0];
  assign bus   = s_tdata[8:1];
  assign slot  = s_tdata[13:9];
  assign func  = s_tdata[16:14];
  assign where = s_tdata[28:17];
  assign size  = s_tdata[31:29];
  assign wdata = s_tdata[63:32];

  assign s_tready = !fifo_full && !clearing;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    is_pf     = func == 3'd0;
    not_found = bus != 8'd0 || slot != 5'd0 || {1'b0, func} >= 4'(NFUNC) ||
                (!is_pf && func > cfg.vf_count);
    bad       = ({1'b0, where} + 13'(size)) > 13'(SPACE_BYTES) ||
                !(size == 3'd1 || size == 3'd2 || size == 3'd4);
    bar_hit   = size == 3'd4 && where >= OFF_BAR_BASE && where < OFF_BAR_END;
    rom_hit   = size == 3'd4 && where == OFF_ROM;
    sbar_hit  = is_pf && size == 3'd4 && where >= SBAR && where < SEND;
    sreg_hit  = is_pf && where >= S && where < SEND;
    ident     = where == 12'h000 || where == 12'h002 || where == 12'h008 ||
                where == 12'h009 || where == 12'h00A || where == 12'h00E ||
                where == 12'h02C || where == 12'h02E || where == 12'h034;
    drop      = !(bar_hit || rom_hit || sbar_hit || sreg_hit) && ident;
    bar_off   = bar_hit ? where - OFF_BAR_BASE : where - SBAR;
    bar_num   = bar_off[4:2];
    case (bar_num)
      3'd0:    bar_data = (wdata & ~MASK) | {28'd0, cfg.bar_flag_bits};
      3'd1:    bar_data = wdata;
      default: bar_data = 32'd0;
    endcase

    op        = '0;
    op.func   = func;
    op.is_wr  = is_wr;
    op.status = not_found ? ST_NOT_FOUND : (bad ? ST_BAD_REG : ST_OK);
    if (bar_hit || sbar_hit) begin
      op.wdata = bar_data;
    end else if (rom_hit) begin
      op.wdata = 32'd0;
    end else begin
      op.wdata = wdata;
    end
    for (int l = 0; l < 4; l++) begin
      sel = 2'(l) - where[1:0];
      a   = where + 12'(sel);
      op.lanes[l].sel = sel;
      op.lanes[l].row = a[11:2];
      op.lanes[l].ovl = ovl_of(a, is_pf);
      op.lanes[l].en  = !not_found && !bad && ({1'b0, sel} < size) && !(is_wr && drop);
    end
  end

endmodule

FILE: rtl/pss_back.sv
module pss_back #(
  parameter int MAX_VIRTUAL_FUNCS = 7,
  parameter int SPACE_BYTES       = 4096,
  parameter int PCIE_CAP_AT       = 64,
  parameter int SRIOV_CAP_AT      = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  pss_pkg::cfg_t     cfg,
  input  pss_pkg::cfg_evt_t evt,
  input  logic              fifo_valid,
  input  pss_pkg::op_t      fifo_op,
  output logic              pop,
  output logic              clearing,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata
);
  import pss_pkg::*;

  localparam int          NFUNC  = MAX_VIRTUAL_FUNCS + 1;
  localparam int          FUNC_W = $clog2(NFUNC);
  localparam int          ROWS   = SPACE_BYTES / 4;
  localparam int          ROW_W  = $clog2(ROWS);
  localparam int          AW     = FUNC_W + ROW_W;
  localparam int          DEPTH  = NFUNC << ROW_W;
  localparam logic [11:0] C      = 12'(PCIE_CAP_AT);
  localparam logic [11:0] S      = 12'(SRIOV_CAP_AT);
  localparam logic [7:0]  MAXV   = 8'(MAX_VIRTUAL_FUNCS);

  function automatic logic [7:0] tmpl(logic [11:0] a, logic pf);
    logic [7:0]  t;
    logic [11:0] d;
    t = 8'h00;
    d = a - S;
    case (a)
      12'h004: t = 8'h07;
      12'h006: t = 8'h10;
      12'h008: t = 8'h01;
      12'h00C: t = 8'h10;
      12'h00E: t = pf ? 8'h80 : 8'h00;
      12'h034: t = C[7:0];
      12'h03D: t = pf ? 8'h01 : 8'h00;
      default: t = 8'h00;
    endcase
    if (a == C)          t = 8'h10;
    if (a == C + 12'd2)  t = 8'h02;
    if (a == C + 12'd7)  t = 8'h10;
    if (a == C + 12'd12) t = 8'h11;
    if (a == C + 12'd18) t = 8'h11;
    if (pf && a >= S && d < 12'h028 && !(d >= 12'h002 && d <= 12'h00B) &&
        d != 12'h012 && d != 12'h013 && d != 12'h018 && d != 12'h019) begin
      case (d)
        12'h000: t = 8'h10;
        12'h00C: t = MAXV;
        12'h00E: t = MAXV;
        12'h014: t = 8'h01;
        12'h016: t = 8'h01;
        12'h01C: t = 8'h01;
        12'h020: t = 8'h01;
        default: t = 8'h00;
      endcase
    end
    return t;
  endfunction

  function automatic logic [7:0] ovl_byte(ovl_t o, logic pf, cfg_t c);
    logic [23:0] cls;
    logic [15:0] dev;
    logic [7:0]  b;
    cls = pf ? c.pf_class_code : c.vf_class_code;
    dev = pf ? c.pf_device_id : c.vf_device_id;
    case (o)
      OVL_VEN0:  b = c.vendor_id[7:0];
      OVL_VEN1:  b = c.vendor_id[15:8];
      OVL_DEV0:  b = dev[7:0];
      OVL_DEV1:  b = dev[15:8];
      OVL_CLS0:  b = cls[7:0];
      OVL_CLS1:  b = cls[15:8];
      OVL_CLS2:  b = cls[23:16];
      OVL_SUB0:  b = c.subsystem_ids[7:0];
      OVL_SUB1:  b = c.subsystem_ids[15:8];
      OVL_SUB2:  b = c.subsystem_ids[23:16];
      OVL_SUB3:  b = c.subsystem_ids[31:24];
      OVL_SDEV0: b = c.vf_device_id[7:0];
      OVL_SDEV1: b = c.vf_device_id[15:8];
      OVL_NUM0:  b = {5'd0, c.vf_count};
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

  st_t               state;
  st_t               state_next;
  logic [NFUNC-1:0]  pending;
  logic [NFUNC-1:0]  pending_next;
  logic [ROW_W-1:0]  row_cnt;
  logic [FUNC_W-1:0] sf;
  logic              sweep;
  logic              load;
  logic              row_last;
  logic [OVL_N-1:0]  ovl_set [NFUNC];
  op_t               op_q;
  logic              out_valid;
  logic [31:0]       out_rd;
  logic [1:0]        out_st;
  logic [31:0]       res_rd;
  logic [1:0]        res_st;
  logic [7:0]        b;
  lane_t             ln;

  logic              ram_en   [4];
  logic              ram_we   [4];
  logic [AW-1:0]     ram_addr [4];
  logic [7:0]        ram_wd   [4];
  logic [7:0]        ram_rd   [4];

  for (genvar g = 0; g < 4; g++) begin : g_lane
    pss_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .en    (ram_en[g]),
      .we    (ram_we[g]),
      .addr  (ram_addr[g]),
      .wdata (ram_wd[g]),
      .rdata (ram_rd[g])
    );
  end

  assign clearing = pending != '0;
  assign row_last = row_cnt == ROW_W'(ROWS - 1);
  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_st, out_rd};

  always_comb begin
    sf = '0;
    for (int f = NFUNC - 1; f >= 0; f--) begin
      if (pending[f]) sf = FUNC_W'(f);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (pending_next == '0) state_next = ST_IDLE;
      ST_IDLE: begin
        if (pending != '0) begin
          state_next = ST_CLEAR;
        end else if (fifo_valid) begin
          state_next = ST_DATA;
        end
      end
      ST_DATA: if (!out_valid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sweep = state == ST_CLEAR;
    pop   = state == ST_IDLE && pending == '0 && fifo_valid;
    load  = state == ST_DATA && (!out_valid || m_tready);
    pending_next = pending | evt.init[NFUNC-1:0];
    if (sweep && row_last) begin
      pending_next[sf] = 1'b0;
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (sweep) begin
        ram_en[l]   = 1'b1;
        ram_we[l]   = 1'b1;
        ram_addr[l] = {sf, row_cnt};
        ram_wd[l]   = tmpl({10'(row_cnt), 2'(l)}, sf == '0);
      end else begin
        ram_en[l]   = pop && fifo_op.lanes[l].en;
        ram_we[l]   = fifo_op.is_wr;
        ram_addr[l] = {fifo_op.func[FUNC_W-1:0], fifo_op.lanes[l].row[ROW_W-1:0]};
        ram_wd[l]   = 8'(fifo_op.wdata >> {fifo_op.lanes[l].sel, 3'b000});
      end
    end
  end

  always_comb begin
    res_rd = 32'd0;
    res_st = op_q.status;
    b      = 8'h00;
    ln     = '0;
    for (int l = 0; l < 4; l++) begin
      ln = op_q.lanes[l];
      b  = ram_rd[l];
      if (ln.ovl != OVL_NONE && !ovl_set[op_q.func[FUNC_W-1:0]][ln.ovl]) begin
        if (ln.ovl == OVL_BARF || ln.ovl == OVL_SBARF) begin
          b = {b[7:4], cfg.bar_flag_bits};
        end else begin
          b = ovl_byte(ln.ovl, op_q.func == 3'd0, cfg);
        end
      end
      if (ln.en && !op_q.is_wr) begin
        res_rd[{ln.sel, 3'b000} +: 8] = b;
      end
    end
    if (op_q.status != ST_OK) begin
      res_rd = 32'hFFFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      pending   <= NFUNC'(1);
      row_cnt   <= '0;
      out_valid <= 1'b0;
      for (int f = 0; f < NFUNC; f++) begin
        ovl_set[f] <= '0;
      end
    end else begin
      state   <= state_next;
      pending <= pending_next;
      if (sweep) begin
        row_cnt     <= row_last ? '0 : row_cnt + ROW_W'(1);
        ovl_set[sf] <= '0;
      end
      if (evt.ident) begin
        for (int f = 0; f < NFUNC; f++) begin
          ovl_set[f] <= ovl_set[f] & NUM_MASK;
        end
      end
      if (evt.num) begin
        ovl_set[0] <= ovl_set[0] & ~NUM_MASK;
      end
      if (pop && fifo_op.is_wr) begin
        for (int l = 0; l < 4; l++) begin
          if (fifo_op.lanes[l].en && fifo_op.lanes[l].ovl != OVL_NONE) begin
            ovl_set[fifo_op.func[FUNC_W-1:0]][fifo_op.lanes[l].ovl] <= 1'b1;
          end
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op_q <= fifo_op;
    end
    if (load) begin
      out_rd <= res_rd;
      out_st <= res_st;
    end
  end

endmodule

FILE: rtl/pcie_sriov_config_space.sv
// PCIe configuration space of one physical function and its SR-IOV virtual
// functions on bus 0, slot 0.
// Input channel s_*: one configuration read or write per item.
// Output channel m_*: one item per input item, in order, carrying the read
// data (all ones on error, zero after a write) and a status code.
// Configuration port cfg_*: writes the identity and VF-count registers; the
// user must write it only while no item is in flight, as the block itself
// does not enforce this.
// An accepted item, behind any earlier ones, passes the queue, the byte-lane
// RAMs and op_q, and the output register; the back end serves one item at a
// time. An unaligned access is served like an aligned one: the space is
// held in four byte-lane RAMs, each addressed on its own.
// A two-entry queue sits between the classifier and the memory side; when
// m_tready is low the result waits in the output register and the queue
// keeps taking items until it is full.
// Reset, and every raise of the VF count, start a pass that writes the
// default image of each new function, row by row over its SPACE_BYTES/4
// rows; s_tready stays low meanwhile.
module pcie_sriov_config_space #(
  parameter int MAX_VIRTUAL_FUNCS = 7,
  parameter int SPACE_BYTES       = 4096,
  parameter int PCIE_CAP_AT       = 64,
  parameter int SRIOV_CAP_AT      = 256,
  parameter int BAR0_BYTES        = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // req_type, bus_number, slot_number, function_number, byte_offset,
  // access_size, write_data
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data, status_code, zero fill
  output logic [39:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import pss_pkg::*;

  localparam int NFUNC = MAX_VIRTUAL_FUNCS + 1;

  cfg_t       cfg;
  cfg_evt_t   evt;
  logic [2:0] new_count;
  logic       clearing;
  logic       fifo_full;
  logic       push;
  op_t        op_in;
  logic       pop;
  logic       fifo_valid;
  op_t        fifo_op;

  always_comb begin
    new_count = (cfg_data[2:0] > 3'(MAX_VIRTUAL_FUNCS)) ? 3'(MAX_VIRTUAL_FUNCS)
                                                       : cfg_data[2:0];
    evt = '0;
    if (cfg_we) begin
      if (cfg_index == REG_VF_COUNT) begin
        evt.num = 1'b1;
        for (int f = 1; f < NFUNC; f++) begin
          evt.init[f] = 3'(f) > cfg.vf_count && 3'(f) <= new_count;
        end
      end else begin
        evt.ident = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VF_COUNT:  cfg.vf_count      <= new_count;
        REG_VENDOR:    cfg.vendor_id     <= cfg_data[15:0];
        REG_PF_DEV:    cfg.pf_device_id  <= cfg_data[15:0];
        REG_VF_DEV:    cfg.vf_device_id  <= cfg_data[15:0];
        REG_SUBSYS:    cfg.subsystem_ids <= cfg_data;
        REG_BAR_FLAGS: cfg.bar_flag_bits <= cfg_data[3:0];
        REG_PF_CLASS:  cfg.pf_class_code <= cfg_data[23:0];
        REG_VF_CLASS:  cfg.vf_class_code <= cfg_data[23:0];
        default:       cfg.vf_count      <= cfg.vf_count;
      endcase
    end
  end

  pss_front #(
    .MAX_VIRTUAL_FUNCS (MAX_VIRTUAL_FUNCS),
    .SPACE_BYTES       (SPACE_BYTES),
    .SRIOV_CAP_AT      (SRIOV_CAP_AT),
    .BAR0_BYTES        (BAR0_BYTES)
  ) u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg       (cfg),
    .clearing  (clearing),
    .fifo_full (fifo_full),
    .push      (push),
    .op        (op_in)
  );

  pss_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .op_in  (op_in),
    .full   (fifo_full),
    .pop    (pop),
    .valid  (fifo_valid),
    .op_out (fifo_op)
  );

  pss_back #(
    .MAX_VIRTUAL_FUNCS (MAX_VIRTUAL_FUNCS),
    .SPACE_BYTES       (SPACE_BYTES),
    .PCIE_CAP_AT       (PCIE_CAP_AT),
    .SRIOV_CAP_AT      (SRIOV_CAP_AT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .evt        (evt),
    .fifo_valid (fifo_valid),
    .fifo_op    (fifo_op),
    .pop        (pop),
    .clearing   (clearing),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

FILE: tb/tb_pcie_sriov_config_space.sv
`timescale 1ns / 100ps

module tb_pcie_sriov_config_space;
  import pss_pkg::*;

  localparam int NFN        = 8;
  localparam int SPACE      = 4096;
  localparam int PCIE_AT    = 64;
  localparam int SRIOV_AT   = 256;
  localparam int BAR0_SZ    = 4096;
  localparam int SRIOV_BAR  = SRIOV_AT + 'h24;
  localparam int SRIOV_END  = SRIOV_AT + 'h3C;
  localparam int IDLE_LIMIT = 30000;

  typedef struct {
    bit        is_wr;
    bit [7:0]  bus;
    bit [4:0]  slot;
    bit [2:0]  func;
    bit [11:0] off;
    bit [2:0]  nbytes;
    bit [31:0] wdata;
  } access_t;

  typedef struct {
    bit [31:0] rdata;
    bit [1:0]  status;
  } resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pcie_sriov_config_space u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // shadow of the configuration space
  bit [7:0]  space_mem [NFN][SPACE];
  bit [2:0]  sh_vf_count;
  bit [15:0] sh_vendor, sh_pf_dev, sh_vf_dev;
  bit [31:0] sh_subsys;
  bit [3:0]  sh_flags;
  bit [23:0] sh_pf_class, sh_vf_class;

  resp_t pending_resp[$];
  int    errors = 0;
  int    n_sent = 0;
  int    n_resp = 0;
  int    n_cfg = 0;
  int    tx_idle = 0;
  int    rx_idle = 0;
  bit    stall_go = 0;
  int    stall_len = 0;
  int    rx_left = 0;
  int    quiet = 0;

  function automatic void put8(int f, int o, bit [31:0] v);
    if (o < SPACE) space_mem[f][o] = v[7:0];
  endfunction

  function automatic void put16(int f, int o, bit [31:0] v);
    put8(f, o, v);
    put8(f, o + 1, v >> 8);
  endfunction

  function automatic void put32(int f, int o, bit [31:0] v);
    put16(f, o, v);
    put16(f, o + 2, v >> 16);
  endfunction

  function automatic void put_flags(int f, int o);
    space_mem[f][o] = {space_mem[f][o][7:4], sh_flags};
  endfunction

  function automatic void build_space(int f, bit pf);
    for (int i = 0; i < SPACE; i++) space_mem[f][i] = 8'h00;
    put16(f, 'h00, sh_vendor);
    put16(f, 'h02, pf ? sh_pf_dev : sh_vf_dev);
    put16(f, 'h04, 'h0007);
    put16(f, 'h06, 'h0010);
    put8(f, 'h08, 'h01);
    put8(f, 'h09, sh_pf_class);
    put32(f, 'h09, pf ? sh_pf_class : sh_vf_class);
    put8(f, 'h0C, 16);
    put8(f, 'h0E, pf ? 'h80 : 'h00);
    put32(f, 'h10, sh_flags);
    put32(f, 'h2C, sh_subsys);
    put8(f, 'h34, PCIE_AT);
    put8(f, 'h3D, pf ? 1 : 0);
    put8(f, PCIE_AT, 'h10);
    put16(f, PCIE_AT + 2, 'h0002);
    put32(f, PCIE_AT + 4, 'h10000000);
    put32(f, PCIE_AT + 12, 'h11);
    put16(f, PCIE_AT + 18, 'h0011);
    if (pf) begin
      put16(f, SRIOV_AT, 'h0010);
      put16(f, SRIOV_AT + 'h0C, 7);
      put16(f, SRIOV_AT + 'h0E, 7);
      put16(f, SRIOV_AT + 'h10, sh_vf_count);
      put16(f, SRIOV_AT + 'h14, 1);
      put16(f, SRIOV_AT + 'h16, 1);
      put16(f, SRIOV_AT + 'h1A, sh_vf_dev);
      put32(f, SRIOV_AT + 'h1C, 1);
      put32(f, SRIOV_AT + 'h20, 1);
      put32(f, SRIOV_AT + 'h24, sh_flags);
    end
  endfunction

  // class code at 0x09 is three bytes; the put32 above spills into 0x0C,
  // which is rewritten right after
  function automatic void put_class(int f, bit [23:0] c);
    put8(f, 'h09, c);
    put8(f, 'h0A, c >> 8);
    put8(f, 'h0B, c >> 16);
  endfunction

  function automatic void shadow_reset();
    sh_vf_count = 0; sh_vendor = 0; sh_pf_dev = 0; sh_vf_dev = 0;
    sh_subsys = 0; sh_flags = 0; sh_pf_class = 0; sh_vf_class = 0;
    for (int f = 0; f < NFN; f++)
      for (int i = 0; i < SPACE; i++) space_mem[f][i] = 8'h00;
    build_space(0, 1'b1);
  endfunction

  function automatic void shadow_reg_write(bit [2:0] idx, bit [31:0] v);
    if (idx == REG_VF_COUNT) begin
      for (int f = sh_vf_count; f < v[2:0]; f++) begin
        build_space(f + 1, 1'b0);
        put_class(f + 1, sh_vf_class);
        put8(f + 1, 'h0C, 16);
      end
      sh_vf_count = v[2:0];
      put16(0, SRIOV_AT + 'h10, sh_vf_count);
      return;
    end
    case (idx)
      REG_VENDOR:    sh_vendor = v[15:0];
      REG_PF_DEV:    sh_pf_dev = v[15:0];
      REG_VF_DEV:    sh_vf_dev = v[15:0];
      REG_SUBSYS:    sh_subsys = v;
      REG_BAR_FLAGS: sh_flags = v[3:0];
      REG_PF_CLASS:  sh_pf_class = v[23:0];
      default:       sh_vf_class = v[23:0];
    endcase
    for (int f = 0; f < NFN; f++) begin
      put16(f, 'h00, sh_vendor);
      put16(f, 'h02, f == 0 ? sh_pf_dev : sh_vf_dev);
      put_class(f, f == 0 ? sh_pf_class : sh_vf_class);
      put32(f, 'h2C, sh_subsys);
      put_flags(f, 'h10);
    end
    put16(0, SRIOV_AT + 'h1A, sh_vf_dev);
    put_flags(0, SRIOV_BAR);
  endfunction

  function automatic void bar_store(int f, int o, bit [31:0] v, int base);
    int n;
    n = (o - base) / 4;
    if (n == 0) put32(f, o, (v & ~(BAR0_SZ - 1)) | sh_flags);
    else if (n == 1) put32(f, o, v);
    else put32(f, o, 0);
  endfunction

  function automatic bit is_ident(int o);
    return o == 'h00 || o == 'h02 || o == 'h08 || o == 'h09 || o == 'h0A ||
           o == 'h0E || o == 'h2C || o == 'h2E || o == 'h34;
  endfunction

  function automatic void sized_store(int f, int o, int n, bit [31:0] v);
    if (n == 1) put8(f, o, v);
    else if (n == 2) put16(f, o, v);
    else put32(f, o, v);
  endfunction

  function automatic resp_t predict_access(access_t a);
    resp_t r;
    int    f, o, n;
    f = a.func; o = a.off; n = a.nbytes;
    r.rdata = 32'h0;
    r.status = ST_OK;
    if (a.bus != 0 || a.slot != 0 || (f != 0 && f > sh_vf_count)) begin
      r.rdata = '1; r.status = ST_NOT_FOUND;
      return r;
    end
    if (o + n > SPACE || !(n == 1 || n == 2 || n == 4)) begin
      r.rdata = '1; r.status = ST_BAD_REG;
      return r;
    end
    if (!a.is_wr) begin
      for (int i = 0; i < n; i++) r.rdata[8*i +: 8] = space_mem[f][o + i];
    end else if (n == 4 && o >= OFF_BAR_BASE && o < OFF_BAR_END) begin
      bar_store(f, o, a.wdata, OFF_BAR_BASE);
    end else if (n == 4 && o == OFF_ROM) begin
      put32(f, o, 0);
    end else if (n == 4 && f == 0 && o >= SRIOV_BAR && o < SRIOV_END) begin
      bar_store(f, o, a.wdata, SRIOV_BAR);
    end else if (f == 0 && o >= SRIOV_AT && o < SRIOV_END) begin
      sized_store(f, o, n, a.wdata);
    end else if (!is_ident(o)) begin
      sized_store(f, o, n, a.wdata);
    end
    return r;
  endfunction

  task automatic send_access(access_t a);
    if ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {a.wdata, a.nbytes, a.off, a.func, a.slot, a.bus, a.is_wr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_resp.push_back(predict_access(a));
    n_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_resp.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic reg_write(bit [2:0] idx, bit [31:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_reg_write(idx, v);
    n_cfg++;
  endtask

  function automatic access_t mk(bit w, int f, int o, int n, bit [31:0] d);
    access_t a;
    a.is_wr = w; a.bus = 8'h0; a.slot = 5'h0; a.func = 3'(f);
    a.off = 12'(o); a.nbytes = 3'(n); a.wdata = d;
    return a;
  endfunction

  function automatic access_t rand_access();
    access_t a;
    int      k, sz;
    k = $urandom_range(99);
    a.is_wr = 1'($urandom_range(1));
    a.bus = 8'h0; a.slot = 5'h0;
    a.func = 3'($urandom_range(0, sh_vf_count));
    sz = $urandom_range(2);
    a.nbytes = sz == 0 ? 3'd1 : (sz == 1 ? 3'd2 : 3'd4);
    a.wdata = $urandom_range(7) == 0 ? ($urandom_range(1) ? 32'hFFFFFFFF : 32'h0) : $urandom;
    if (k < 40) a.off = 12'($urandom_range(0, 'h3F));
    else if (k < 55) a.off = 12'(PCIE_AT + $urandom_range(0, 23));
    else if (k < 70) a.off = 12'(SRIOV_AT + $urandom_range(0, 'h3F));
    else if (k < 80) a.off = 12'(SPACE - $urandom_range(1, 6));
    else if (k < 88) a.off = 12'($urandom);
    else begin
      a.bus = $urandom_range(3) == 0 ? 8'($urandom) : 8'h0;
      a.slot = $urandom_range(3) == 0 ? 5'($urandom) : 5'h0;
      a.func = 3'($urandom);
      a.nbytes = 3'($urandom);
      a.off = 12'($urandom);
    end
    return a;
  endfunction

  always @(posedge clk) begin
    if (stall_go) begin
      stall_go = 0;
      rx_left = stall_len;
    end
    if (rx_left > 0) begin
      rx_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    resp_t e;
    if (m_tvalid && m_tready) begin
      n_resp++;
      if (pending_resp.size() == 0) begin
        errors++;
        $display("%0t unexpected item: rdata %h status %0d", $time,
                 m_tdata[31:0], m_tdata[33:32]);
      end else begin
        e = pending_resp.pop_front();
        if (m_tdata[31:0] !== e.rdata) begin
          errors++;
          $display("%0t read_data mismatch: expected %h actual %h", $time,
                   e.rdata, m_tdata[31:0]);
        end
        if (m_tdata[33:32] !== e.status) begin
          errors++;
          $display("%0t status_code mismatch: expected %0d actual %0d", $time,
                   e.status, m_tdata[33:32]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("%0t watchdog: no progress", $time);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic test_directed();
    reg_write(REG_VENDOR, 32'hFFFF);
    reg_write(REG_PF_DEV, 32'h1234);
    reg_write(REG_VF_DEV, 32'hABCD);
    reg_write(REG_SUBSYS, 32'hFFFFFFFF);
    reg_write(REG_BAR_FLAGS, 32'hF);
    reg_write(REG_PF_CLASS, 32'hFFFFFF);
    reg_write(REG_VF_CLASS, 32'h020000);
    send_access(mk(0, 0, 'h000, 4, 0));
    send_access(mk(0, 0, 'hFFF, 1, 0));
    send_access(mk(0, 0, 'hFFE, 4, 0));
    send_access(mk(1, 0, 'hFFD, 4, 32'hFFFFFFFF));
    for (int n = 0; n < 8; n++)
      if (n != 1 && n != 2 && n != 4) send_access(mk(n[0], 0, 'h40, n, 32'h5A5A5A5A));
    send_access(mk(0, 1, 'h000, 4, 0));
    send_access('{1'b0, 8'hFF, 5'h00, 3'h0, 12'h0, 3'h4, 32'h0});
    send_access('{1'b1, 8'h00, 5'h1F, 3'h0, 12'h0, 3'h4, 32'hFFFFFFFF});
    send_access(mk(1, 0, 'h000, 4, 32'hFFFFFFFF));
    send_access(mk(1, 0, 'h001, 2, 32'h0000BEEF));
    send_access(mk(1, 0, 'h010, 4, 32'hFFFFFFFF));
    send_access(mk(1, 0, 'h014, 4, 32'hFFFFFFFF));
    send_access(mk(1, 0, 'h018, 4, 32'hFFFFFFFF));
    send_access(mk(1, 0, 'h011, 4, 32'h12345678));
    send_access(mk(1, 0, 'h030, 4, 32'hFFFFFFFF));
    send_access(mk(1, 0, SRIOV_BAR, 4, 32'hFFFFFFFF));
    send_access(mk(1, 0, SRIOV_AT + 'h10, 2, 32'hFFFF));
    for (int o = 'h0; o < 'h40; o += 4) send_access(mk(0, 0, o, 4, 0));
    send_access(mk(0, 0, SRIOV_AT + 'h10, 4, 0));
    send_access(mk(0, 0, SRIOV_BAR, 4, 0));
    reg_write(REG_VF_COUNT, 7);
    send_access(mk(0, 7, 'h000, 4, 0));
    send_access(mk(0, 7, 'h00C, 4, 0));
    reg_write(REG_VF_COUNT, 2);
    send_access(mk(0, 3, 'h000, 4, 0));
    reg_write(REG_VF_COUNT, 4);
    drain();
  endtask

  task automatic test_random(int items);
    for (int i = 0; i < items; i++) begin
      if (i % 140 == 139) begin
        if ($urandom_range(1)) reg_write(REG_VF_COUNT, $urandom_range(0, 7));
        else reg_write(3'($urandom_range(1, 7)), $urandom);
      end
      send_access(rand_access());
    end
    drain();
  endtask

  task automatic test_backpressure();
    stall_len = 400;
    stall_go = 1;
    for (int i = 0; i < 30; i++) send_access(rand_access());
    drain();
  endtask

  task automatic test_extremes();
    reg_write(REG_VF_COUNT, 0);
    reg_write(REG_VENDOR, 0);
    reg_write(REG_PF_DEV, 0);
    reg_write(REG_VF_DEV, 32'hFFFF);
    reg_write(REG_SUBSYS, 0);
    reg_write(REG_BAR_FLAGS, 0);
    reg_write(REG_PF_CLASS, 0);
    reg_write(REG_VF_CLASS, 32'hFFFFFF);
    reg_write(REG_VF_COUNT, 7);
    test_random(120);
  endtask

  initial begin
    shadow_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    tx_idle = 29; rx_idle = 57;
    test_random(560);
    tx_idle = 57; rx_idle = 29;
    test_random(560);
    tx_idle = 0; rx_idle = 0;
    test_backpressure();
    test_extremes();
    test_random(460);
    $display("covered %0d accesses, %0d results, %0d register writes", n_sent, n_resp, n_cfg);
    $display("errors seen: %0d", errors);
    if (errors == 0 && pending_resp.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
